FILE: rtl/ttc_pkg.sv
// Shared types and constants for the text console cursor engine.
package ttc_pkg;

	// Field widths of the request and result items.
	localparam int ROW_W  = 5;
	localparam int COL_W  = 7;
	localparam int CHAR_W = 8;
	localparam int CELL_W = 16;
	localparam int ACT_W  = 3;

	// Action codes.
	localparam logic [ACT_W-1:0] ACT_PUT   = 3'd0;
	localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd1;
	localparam logic [ACT_W-1:0] ACT_SET   = 3'd2;
	localparam logic [ACT_W-1:0] ACT_WRITE = 3'd3;
	localparam logic [ACT_W-1:0] ACT_READ  = 3'd4;

	// Character codes with a meaning of their own.
	localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
	localparam logic [CHAR_W-1:0] CH_BS     = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_BLANK  = 8'h20;
	localparam logic [CHAR_W-1:0] CH_PR_MAX = 8'h7F;

	localparam logic [CHAR_W-1:0] COLOR_RESET = 8'h0F;

	// Screen position.
	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} pos_t;

	// Request to the position stepping unit.
	typedef struct packed {
		pos_t pos;
		logic dec;
	} step_req_t;

	// Answer of the position stepping unit.
	typedef struct packed {
		pos_t pos;
		logic wrap_end;
	} step_rsp_t;

	// Screen memory access for one cycle.
	typedef struct packed {
		logic              we;
		pos_t              wpos;
		logic [CELL_W-1:0] wdata;
		pos_t              rpos;
	} mem_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_PRINT,
		ST_SWEEP,
		ST_DRAIN,
		ST_READ,
		ST_FINISH
	} state_t;

endpackage

FILE: rtl/ttc_pos_step.sv
// Shared position stepping unit: moves a screen position one cell forward or back.
module ttc_pos_step #(
	parameter int ROWS    = 25,
	parameter int COLUMNS = 80
) (
	input  ttc_pkg::step_req_t req,
	output ttc_pkg::step_rsp_t rsp
);
	import ttc_pkg::*;

	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
	localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);

	// Forward steps wrap to the next row; stepping past the last cell keeps the row
	// and flags the end. Backward steps wrap to the row above; home flags the end.
	always_comb begin
		rsp.pos      = req.pos;
		rsp.wrap_end = 1'b0;
		if (!req.dec) begin
			if (req.pos.col == COL_LAST) begin
				rsp.pos.col = '0;
				if (req.pos.row == ROW_LAST) begin
					rsp.wrap_end = 1'b1;
				end else begin
					rsp.pos.row = req.pos.row + 1'b1;
				end
			end else begin
				rsp.pos.col = req.pos.col + 1'b1;
			end
		end else begin
			if (req.pos.col == '0) begin
				if (req.pos.row == '0) begin
					rsp.wrap_end = 1'b1;
				end else begin
					rsp.pos.row = req.pos.row - 1'b1;
					rsp.pos.col = COL_LAST;
				end
			end else begin
				rsp.pos.col = req.pos.col - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/ttc_screen_ram.sv
// Screen cell memory with one write port and one registered read port.
module ttc_screen_ram #(
	parameter int DEPTH = 3200,
	parameter int AW    = 12
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [ttc_pkg::CELL_W-1:0] wdata,
	input  logic [AW-1:0]              raddr,
	output logic [ttc_pkg::CELL_W-1:0] rdata
);
	import ttc_pkg::*;

	logic [CELL_W-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/ttc_ctrl.sv
// Sequencer of the console: decodes requests, drives the stepping unit and the screen memory.
module ttc_ctrl #(
	parameter int ROWS       = 25,
	parameter int COLUMNS    = 80,
	parameter int TAB_SPACES = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write_en,
	input  logic [ttc_pkg::CHAR_W-1:0] cfg_write_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [ttc_pkg::ACT_W-1:0]  action,
	input  logic [ttc_pkg::CHAR_W-1:0] char_code,
	input  logic [ttc_pkg::ROW_W-1:0]  row,
	input  logic [ttc_pkg::COL_W-1:0]  col,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [ttc_pkg::ROW_W-1:0]  cursor_row_out,
	output logic [ttc_pkg::COL_W-1:0]  cursor_col_out,
	output logic [ttc_pkg::CELL_W-1:0] cell_value,
	output logic                       scrolled,
	output ttc_pkg::step_req_t         step_req,
	input  ttc_pkg::step_rsp_t         step_rsp,
	output ttc_pkg::mem_req_t          mem_req,
	input  logic [ttc_pkg::CELL_W-1:0] mem_rdata
);
	import ttc_pkg::*;

	localparam int CNT_W = $clog2(TAB_SPACES + 1);
	localparam logic [CNT_W-1:0] TAB_CNT = CNT_W'(TAB_SPACES);
	localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);
	localparam logic [ROW_W:0]   ROWS_V  = (ROW_W + 1)'(ROWS);
	localparam logic [COL_W:0]   COLS_V  = (COL_W + 1)'(COLUMNS);
	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
	localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);

	state_t            state_q, state_d;
	pos_t              cur_q, cur_d;
	pos_t              ptr_q, ptr_d;
	logic [ACT_W-1:0]  act_q;
	logic [CHAR_W-1:0] chr_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [CHAR_W-1:0] color_q;
	logic [CHAR_W-1:0] pchar_q, pchar_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic              clear_q, clear_d;
	logic              scr_q, scr_d;
	logic [CELL_W-1:0] cell_q, cell_d;
	logic              wr_s1, wr_d;
	pos_t              wpos_s1;
	logic              blank_s1, blank_d;
	logic              accept;
	logic              fin_load;
	logic              in_rng;
	logic              printable;
	logic              out_valid_q;
	logic [ROW_W-1:0]  out_row_q;
	logic [COL_W-1:0]  out_col_q;
	logic [CELL_W-1:0] out_cell_q;
	logic              out_scr_q;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign in_rng    = ({1'b0, row_q} < ROWS_V) && ({1'b0, col_q} < COLS_V);
	assign printable = (chr_q >= CH_BLANK) && (chr_q <= CH_PR_MAX);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= COLOR_RESET;
		end else if (cfg_write_en) begin
			color_q <= cfg_write_data;
		end
	end

	// Operand selection for the shared stepping unit.
	always_comb begin
		step_req.pos = cur_q;
		step_req.dec = 1'b0;
		unique case (state_q)
			ST_EXEC: begin
				if (act_q == ACT_PUT && chr_q == CH_LF) begin
					step_req.pos.col = COL_LAST;
				end
				if (act_q == ACT_PUT && chr_q == CH_BS) begin
					step_req.dec = 1'b1;
				end
			end
			ST_SWEEP: step_req.pos = ptr_q;
			default: ;
		endcase
	end

	// Next state and datapath controls.
	always_comb begin
		state_d  = state_q;
		cur_d    = cur_q;
		ptr_d    = ptr_q;
		cnt_d    = cnt_q;
		clear_d  = clear_q;
		scr_d    = scr_q;
		cell_d   = cell_q;
		pchar_d  = pchar_q;
		wr_d     = 1'b0;
		blank_d  = 1'b0;
		fin_load = 1'b0;
		mem_req.we       = 1'b0;
		mem_req.wpos     = cur_q;
		mem_req.wdata    = {color_q, CH_BLANK};
		mem_req.rpos.row = ptr_q.row + 1'b1;
		mem_req.rpos.col = ptr_q.col;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cell_d  = '0;
					scr_d   = 1'b0;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_FINISH;
				unique case (act_q)
					ACT_PUT: begin
						unique case (chr_q)
							CH_LF: begin
								cur_d = step_rsp.pos;
								if (step_rsp.wrap_end) begin
									scr_d   = 1'b1;
									clear_d = 1'b0;
									cnt_d   = '0;
									ptr_d   = '0;
									state_d = ST_SWEEP;
								end
							end
							CH_CR: cur_d.col = '0;
							CH_BS: begin
								if (!step_rsp.wrap_end) begin
									cur_d        = step_rsp.pos;
									mem_req.we   = 1'b1;
									mem_req.wpos = step_rsp.pos;
								end
							end
							CH_TAB: begin
								cnt_d   = TAB_CNT;
								pchar_d = CH_BLANK;
								state_d = ST_PRINT;
							end
							default: begin
								if (printable) begin
									cnt_d   = ONE_CNT;
									pchar_d = chr_q;
									state_d = ST_PRINT;
								end
							end
						endcase
					end
					ACT_CLEAR: begin
						cur_d   = '0;
						ptr_d   = '0;
						clear_d = 1'b1;
						cnt_d   = '0;
						state_d = ST_SWEEP;
					end
					ACT_SET: begin
						if (in_rng) begin
							cur_d.row = row_q;
							cur_d.col = col_q;
						end
					end
					ACT_WRITE: begin
						if (in_rng && chr_q != CH_NUL) begin
							mem_req.we       = 1'b1;
							mem_req.wpos.row = row_q;
							mem_req.wpos.col = col_q;
							mem_req.wdata    = {color_q, chr_q};
						end
					end
					ACT_READ: begin
						mem_req.rpos.row = row_q;
						mem_req.rpos.col = col_q;
						if (in_rng) begin
							state_d = ST_READ;
						end
					end
					default: ;
				endcase
			end
			ST_PRINT: begin
				mem_req.we    = 1'b1;
				mem_req.wdata = {color_q, pchar_q};
				cur_d         = step_rsp.pos;
				cnt_d         = cnt_q - 1'b1;
				if (step_rsp.wrap_end) begin
					scr_d   = 1'b1;
					clear_d = 1'b0;
					ptr_d   = '0;
					state_d = ST_SWEEP;
				end else if (cnt_q != ONE_CNT) begin
					state_d = ST_PRINT;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_SWEEP: begin
				// Read the cell one row below while the previous cell is written.
				wr_d    = 1'b1;
				blank_d = clear_q || (ptr_q.row == ROW_LAST);
				ptr_d   = step_rsp.pos;
				if (step_rsp.wrap_end) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = (cnt_q != '0) ? ST_PRINT : ST_FINISH;
			end
			ST_READ: begin
				cell_d  = mem_rdata;
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					fin_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		// The sweep write stage owns the write port while it is busy.
		if (wr_s1) begin
			mem_req.we    = 1'b1;
			mem_req.wpos  = wpos_s1;
			mem_req.wdata = blank_s1 ? {color_q, CH_BLANK} : mem_rdata;
		end
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Cursor and sequencer control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q   <= '0;
			cnt_q   <= '0;
			clear_q <= 1'b0;
			scr_q   <= 1'b0;
			wr_s1   <= 1'b0;
		end else begin
			cur_q   <= cur_d;
			cnt_q   <= cnt_d;
			clear_q <= clear_d;
			scr_q   <= scr_d;
			wr_s1   <= wr_d;
		end
	end

	// Request fields, sweep pointer and payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= action;
			chr_q <= char_code;
			row_q <= row;
			col_q <= col;
		end
		ptr_q    <= ptr_d;
		pchar_q  <= pchar_d;
		cell_q   <= cell_d;
		wpos_s1  <= ptr_q;
		blank_s1 <= blank_d;
	end

	// Result register: holds one result while the next request is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			out_row_q  <= cur_q.row;
			out_col_q  <= cur_q.col;
			out_cell_q <= cell_q;
			out_scr_q  <= scr_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign cursor_row_out = out_row_q;
	assign cursor_col_out = out_col_q;
	assign cell_value     = out_cell_q;
	assign scrolled       = out_scr_q;

	// The cursor never leaves the screen.
	a_cursor_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, cur_q.row} < ROWS_V) && ({1'b0, cur_q.col} < COLS_V))
		else $error("cursor outside the screen");

	// Sweep writes only follow a sweep read.
	a_sweep_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr_s1 |-> (state_q == ST_SWEEP || state_q == ST_DRAIN))
		else $error("sweep write outside a sweep");

	// A print pass always has a cell left to print.
	a_print_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PRINT |-> cnt_q != '0)
		else $error("print pass with empty count");

	// A sweep that is not a clear is a scroll and must be reported.
	a_scroll_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP && !clear_q) |-> scr_q)
		else $error("scroll sweep without scroll flag");

endmodule

FILE: rtl/text_console_cursor_engine.sv
// Top level of the text console cursor engine: sequencer, stepping unit and screen memory.
// Set cursor, write at position, carriage return, newline, backspace and ignored bytes
// finish after the decode state; a read also waits for the registered memory read, and
// printed bytes and tabs (TAB_SPACES blanks) pass through the print state. A scroll or a
// clear adds a sweep of the whole screen memory. One request is in work at a time.
// Reset clears the cursor and sets the colour to 0x0F; screen cells stay undefined until written.
module text_console_cursor_engine #(
	parameter int ROWS       = 25,
	parameter int COLUMNS    = 80,
	parameter int TAB_SPACES = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write_en,
	input  logic [ttc_pkg::CHAR_W-1:0] cfg_write_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [ttc_pkg::ACT_W-1:0]  action,
	input  logic [ttc_pkg::CHAR_W-1:0] char_code,
	input  logic [ttc_pkg::ROW_W-1:0]  row,
	input  logic [ttc_pkg::COL_W-1:0]  col,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [ttc_pkg::ROW_W-1:0]  cursor_row_out,
	output logic [ttc_pkg::COL_W-1:0]  cursor_col_out,
	output logic [ttc_pkg::CELL_W-1:0] cell_value,
	output logic                       scrolled
);
	import ttc_pkg::*;

	localparam int RB    = $clog2(ROWS);
	localparam int CB    = $clog2(COLUMNS);
	localparam int AW    = RB + CB;
	localparam int DEPTH = ROWS * (2 ** CB);

	step_req_t         step_req;
	step_rsp_t         step_rsp;
	mem_req_t          mem_req;
	logic [CELL_W-1:0] mem_rdata;
	logic [AW-1:0]     waddr;
	logic [AW-1:0]     raddr;

	// Row and column bits form the cell address directly.
	assign waddr = {mem_req.wpos.row[RB-1:0], mem_req.wpos.col[CB-1:0]};
	assign raddr = {mem_req.rpos.row[RB-1:0], mem_req.rpos.col[CB-1:0]};

	ttc_ctrl #(
		.ROWS       (ROWS),
		.COLUMNS    (COLUMNS),
		.TAB_SPACES (TAB_SPACES)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.action         (action),
		.char_code      (char_code),
		.row            (row),
		.col            (col),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.cursor_row_out (cursor_row_out),
		.cursor_col_out (cursor_col_out),
		.cell_value     (cell_value),
		.scrolled       (scrolled),
		.step_req       (step_req),
		.step_rsp       (step_rsp),
		.mem_req        (mem_req),
		.mem_rdata      (mem_rdata)
	);

	ttc_pos_step #(
		.ROWS    (ROWS),
		.COLUMNS (COLUMNS)
	) u_step (
		.req (step_req),
		.rsp (step_rsp)
	);

	ttc_screen_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (waddr),
		.wdata (mem_req.wdata),
		.raddr (raddr),
		.rdata (mem_rdata)
	);

endmodule
